// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while out of reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge while out of reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/gm3_pkg.sv =====
// Shared types, constants and helpers of the 3x3 gradient magnitude block.
`timescale 1ns / 1ps
package gm3_pkg;

  // Field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned POS_W  = 2;
  localparam int unsigned MAG_W  = 10;
  localparam int unsigned SUM_W  = 11;
  localparam int unsigned ABS_W  = SUM_W - 1;
  localparam int unsigned SQ_W   = 2 * ABS_W;
  localparam int unsigned RAD_W  = SQ_W + 2;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 1;

  // Stream data widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 16;

  // Square root iterations, one result bit each
  localparam int unsigned ROOT_STEPS = ROOT_W;
  localparam int unsigned CNT_W      = $clog2(ROOT_STEPS);

  // Accumulator clamp bound
  localparam logic signed [SUM_W:0] SUM_MAX = 12'sd1023;
  localparam logic signed [SUM_W:0] SUM_MIN = -12'sd1023;

  // Mask selector codes
  localparam logic MASK_HORZ = 1'b0;

  // Window positions
  localparam logic [POS_W-1:0] POS_FIRST = 2'd0;
  localparam logic [POS_W-1:0] POS_MID   = 2'd1;
  localparam logic [POS_W-1:0] POS_LAST  = 2'd2;

  typedef enum logic [1:0] {
    COEF_ZERO,
    COEF_NEG,
    COEF_POS
  } coef_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accumulate;
    logic square;
    logic root_step;
    logic emit;
  } gm3_cmd_t;

  // Central-difference coefficient of one window position
  function automatic coef_e coef_of(input logic mask, input logic [POS_W-1:0] row,
                                    input logic [POS_W-1:0] col);
    coef_e c;
    c = COEF_ZERO;
    if (mask == MASK_HORZ) begin
      if (row == POS_MID && col == POS_FIRST) c = COEF_NEG;
      if (row == POS_MID && col == POS_LAST)  c = COEF_POS;
    end else begin
      if (row == POS_FIRST && col == POS_MID) c = COEF_NEG;
      if (row == POS_LAST  && col == POS_MID) c = COEF_POS;
    end
    return c;
  endfunction

endpackage

// ===== rtl/gm3_datapath.sv =====
// Datapath: saturating accumulators, squares, bit-serial square root, result register.
`timescale 1ns / 1ps
module gm3_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gm3_pkg::gm3_cmd_t          cmd_i,
  input  logic                       mask_select_i,
  input  logic [gm3_pkg::POS_W-1:0]  win_row_i,
  input  logic [gm3_pkg::POS_W-1:0]  win_col_i,
  input  logic [gm3_pkg::PIX_W-1:0]  pixel_i,
  output logic [gm3_pkg::MAG_W-1:0]  magnitude_o
);
  import gm3_pkg::*;

  logic signed [SUM_W-1:0] sum_h_q, sum_h_d;
  logic signed [SUM_W-1:0] sum_v_q, sum_v_d;
  logic signed [PIX_W:0]   term;
  logic signed [SUM_W-1:0] sum_sel;
  logic signed [SUM_W-1:0] sum_new;
  coef_e                   coef;

  logic [SUM_W-1:0] neg_h, neg_v;
  logic [ABS_W-1:0] abs_h, abs_v;
  logic [SQ_W-1:0]  sq_h, sq_v;
  logic [RAD_W-1:0] radicand;

  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_q;
  logic [REM_W+1:0]  rem_t, trial, diff;
  logic              ge;
  logic [MAG_W-1:0]  mag_q;

  // Add and clamp to the accumulator range
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] acc,
                                                      input logic signed [PIX_W:0] t);
    logic signed [SUM_W:0] s;
    s = {acc[SUM_W-1], acc} + {{(SUM_W - PIX_W){t[PIX_W]}}, t};
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    return s[SUM_W-1:0];
  endfunction

  // Weight the pixel by its coefficient
  always_comb begin
    coef = coef_of(mask_select_i, win_row_i, win_col_i);
    case (coef)
      COEF_NEG: term = -$signed({1'b0, pixel_i});
      COEF_POS: term = $signed({1'b0, pixel_i});
      default:  term = '0;
    endcase
  end

  assign sum_sel = (mask_select_i == MASK_HORZ) ? sum_h_q : sum_v_q;
  assign sum_new = sat_add(sum_sel, term);

  // Update the selected accumulator, clear both when the square is taken
  always_comb begin
    sum_h_d = sum_h_q;
    sum_v_d = sum_v_q;
    if (cmd_i.square) begin
      sum_h_d = '0;
      sum_v_d = '0;
    end else if (cmd_i.accumulate) begin
      if (mask_select_i == MASK_HORZ) begin
        sum_h_d = sum_new;
      end else begin
        sum_v_d = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_h_q <= '0;
      sum_v_q <= '0;
    end else begin
      sum_h_q <= sum_h_d;
      sum_v_q <= sum_v_d;
    end
  end

  // Absolute values and squares; the bound keeps magnitudes within ABS_W bits
  assign neg_h    = -sum_h_q;
  assign neg_v    = -sum_v_q;
  assign abs_h    = sum_h_q[SUM_W-1] ? neg_h[ABS_W-1:0] : sum_h_q[ABS_W-1:0];
  assign abs_v    = sum_v_q[SUM_W-1] ? neg_v[ABS_W-1:0] : sum_v_q[ABS_W-1:0];
  assign sq_h     = abs_h * abs_h;
  assign sq_v     = abs_v * abs_v;
  assign radicand = {2'b00, sq_h} + {2'b00, sq_v};

  // One digit of the square root: bring down two radicand bits, try the next root bit
  assign rem_t = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign diff  = rem_t - trial;
  assign ge    = (rem_t >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      rad_q  <= radicand;
      root_q <= '0;
      rem_q  <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      root_q <= {root_q[ROOT_W-2:0], ge};
      rem_q  <= ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
    end
  end

  // Hold the halved root for the output beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mag_q <= root_q[ROOT_W-1:1];
    end
  end

  assign magnitude_o = mag_q;

endmodule

// ===== rtl/gm3_ctrl.sv =====
// Controller: sequences accumulate, square, root iterations and the output beat.
`timescale 1ns / 1ps
module gm3_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gm3_pkg::gm3_cmd_t cmd_o
);
  import gm3_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             accept;
  logic             load_out;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign load_out = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // State, iteration count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the beat is taken
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && in_last_i) state_q <= ST_SQUARE;
        end
        ST_SQUARE: begin
          cnt_q   <= '0;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_out) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign cmd_o.accumulate = accept;
  assign cmd_o.square     = (state_q == ST_SQUARE);
  assign cmd_o.root_step  = (state_q == ST_ROOT);
  assign cmd_o.emit       = load_out;

endmodule

// ===== rtl/gradient_magnitude_3x3.sv =====
// Top level: 3x3 central-difference gradient magnitude over a pixel stream.
// A beat without tlast leaves tready high, so the next beat follows at once.
// After a tlast beat tready is low while the block squares the sums, runs the bit-serial
// square root and loads the output register, which raises m_axis_tvalid.
// An earlier result not yet taken holds the load, and tready, until that result is taken.
// Reset (rst_ni low, asynchronous) clears both accumulators and drops m_axis_tvalid.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gradient_magnitude_3x3 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gm3_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // win_row[1:0], win_col[3:2], pixel[11:4]
  input  logic                            s_axis_tuser,  // mask_select[0]
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gm3_pkg::M_TDATA_W-1:0]   m_axis_tdata   // magnitude[9:0]
);
  import gm3_pkg::*;

  gm3_cmd_t         cmd;
  logic [MAG_W-1:0] magnitude;
  logic             in_beat;

  // Sequence the work on each window
  gm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Unpack the beat and compute
  gm3_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mask_select_i (s_axis_tuser),
    .win_row_i     (s_axis_tdata[POS_W-1:0]),
    .win_col_i     (s_axis_tdata[2*POS_W-1:POS_W]),
    .pixel_i       (s_axis_tdata[2*POS_W+PIX_W-1:2*POS_W]),
    .magnitude_o   (magnitude)
  );

  assign m_axis_tdata = {{(M_TDATA_W - MAG_W){1'b0}}, magnitude};
  assign in_beat      = s_axis_tvalid && s_axis_tready;

  // A window end closes the input until its result is computed
  `ASSERT_CLK(a_last_stalls, (in_beat && s_axis_tlast) |=> !s_axis_tready, "input open after last")
  // An inner beat keeps the input open
  `ASSERT_CLK(a_inner_flows, (in_beat && !s_axis_tlast) |=> s_axis_tready, "inner beat stalled")
  // A new result only appears after the root was computed with the input closed
  `ASSERT_CLK(a_result_after_root, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "early result")
  // The halved root stays within its range
  `ASSERT_NEVER(a_mag_range, m_axis_tvalid && (magnitude > 10'd723), "magnitude out of range")

endmodule

// ===== tb/sv/tb_gradient_magnitude_3x3.sv =====
// Self-checking testbench of the 3x3 central-difference gradient magnitude block.
`timescale 1ns / 1ps
module tb_gradient_magnitude_3x3;
  import gm3_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 10;
  localparam int SUM_LIMIT       = 1023;
  localparam int RANDOM_PIXELS   = 1000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES     = 40;
  localparam int CYCLE_LIMIT     = 1000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // win_row[1:0], win_col[3:2], pixel[11:4]
  logic                 s_axis_tuser;   // mask_select[0]
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // magnitude[9:0]

  // Predicted gradient sums of the open window
  logic signed [SUM_W-1:0] grad_x;
  logic signed [SUM_W-1:0] grad_y;

  logic [MAG_W-1:0] expected_mags[$];
  int               mismatch_count  = 0;
  int               pixels_sent     = 0;
  int               windows_checked = 0;
  int               cycle_count     = 0;
  bit               no_idle         = 1'b0;
  bit               hold_off_req    = 1'b0;

  gradient_magnitude_3x3 u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // End a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d windows pending", $time, expected_mags.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Weight of a window position in the selected mask
  function automatic int tap_weight(logic mask, logic [POS_W-1:0] row, logic [POS_W-1:0] col);
    if (mask == MASK_HORZ) begin
      if (row == POS_MID && col == POS_FIRST) return -1;
      if (row == POS_MID && col == POS_LAST) return 1;
    end else begin
      if (row == POS_FIRST && col == POS_MID) return -1;
      if (row == POS_LAST && col == POS_MID) return 1;
    end
    return 0;
  endfunction

  function automatic int clamp_sum(int s);
    if (s > SUM_LIMIT) return SUM_LIMIT;
    if (s < -SUM_LIMIT) return -SUM_LIMIT;
    return s;
  endfunction

  // Half of the rounded-down square root of gx^2 + gy^2
  function automatic logic [MAG_W-1:0] window_magnitude(int gx, int gy);
    int sq;
    int root;
    int cand;
    sq   = gx * gx + gy * gy;
    root = 0;
    for (int b = 11; b >= 0; b--) begin
      cand = root | (1 << b);
      if (cand * cand <= sq) root = cand;
    end
    return MAG_W'(root >> 1);
  endfunction

  // Accumulate one accepted pixel; close the window on last
  task automatic accumulate_pixel(logic mask, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                  logic [PIX_W-1:0] pix, logic last);
    int term;
    term = int'(pix) * tap_weight(mask, row, col);
    if (mask == MASK_HORZ) grad_x = SUM_W'(clamp_sum(int'(grad_x) + term));
    else grad_y = SUM_W'(clamp_sum(int'(grad_y) + term));
    if (last) begin
      expected_mags.push_back(window_magnitude(int'(grad_x), int'(grad_y)));
      grad_x = '0;
      grad_y = '0;
    end
  endtask

  // Offer one pixel beat after a random gap and hold it until taken
  task automatic send_pixel(logic mask, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                            logic [PIX_W-1:0] pix, logic last);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, pix, col, row};
    s_axis_tuser  <= mask;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
    accumulate_pixel(mask, row, col, pix, last);
  endtask

  // Drop valid and wait until every window result has come back
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_mags.size() != 0) @(posedge clk_i);
  endtask

  // Random window; a bias of 0 or 1 favors the negative or positive tap
  task automatic send_random_window(int len, int bias);
    logic             mask;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] pix;
    int               sel;
    bit               pos_tap;
    for (int i = 0; i < len; i++) begin
      mask    = 1'($urandom_range(0, 1));
      sel     = $urandom_range(0, 9);
      pos_tap = (bias >= 0) ? bias[0] : sel[0];
      if (sel < 6) begin
        if (mask == MASK_HORZ) begin
          row = POS_MID;
          col = pos_tap ? POS_LAST : POS_FIRST;
        end else begin
          col = POS_MID;
          row = pos_tap ? POS_LAST : POS_FIRST;
        end
      end else begin
        row = POS_W'($urandom_range(0, 3));
        col = POS_W'($urandom_range(0, 3));
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) pix = '0;
      else if (sel == 1) pix = '1;
      else if (bias >= 0) pix = PIX_W'($urandom_range(128, 255));
      else pix = PIX_W'($urandom_range(0, 255));
      send_pixel(mask, row, col, pix, i == len - 1);
    end
  endtask

  // Extremes, dead taps, saturation in both directions
  task automatic test_directed();
    send_pixel(1'b0, POS_MID, POS_FIRST, 8'd255, 1'b1);
    send_pixel(1'b1, POS_FIRST, POS_MID, 8'd200, 1'b0);
    send_pixel(1'b1, POS_LAST, POS_MID, 8'd55, 1'b1);
    send_pixel(1'b0, 2'd3, 2'd3, 8'd255, 1'b0);
    send_pixel(1'b1, 2'd3, POS_MID, 8'd255, 1'b0);
    send_pixel(1'b0, POS_MID, 2'd3, 8'd255, 1'b1);
    repeat (5) send_pixel(1'b0, POS_MID, POS_LAST, 8'd255, 1'b0);
    repeat (4) send_pixel(1'b1, POS_LAST, POS_MID, 8'd255, 1'b0);
    send_pixel(1'b1, POS_LAST, POS_MID, 8'd255, 1'b1);
    repeat (4) send_pixel(1'b0, POS_MID, POS_FIRST, 8'd255, 1'b0);
    send_pixel(1'b0, POS_MID, POS_FIRST, 8'd255, 1'b1);
    send_pixel(1'b0, POS_FIRST, POS_FIRST, 8'd255, 1'b0);
    send_pixel(1'b1, POS_MID, POS_MID, 8'd0, 1'b1);
    wait_for_drain();
  endtask

  // Mostly well-formed windows, some long enough to saturate
  task automatic test_random_windows(int target);
    int stop_at;
    stop_at = pixels_sent + target;
    while (pixels_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
      if ($urandom_range(0, 99) < 85) send_random_window($urandom_range(1, 9), -1);
      else send_random_window($urandom_range(16, 40), $urandom_range(0, 1));
      if ($urandom_range(0, 24) == 0) wait_for_drain();
    end
    no_idle = 1'b0;
    wait_for_drain();
  endtask

  // Hold the output off while short windows keep coming
  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    repeat (40) send_random_window($urandom_range(1, 3), -1);
    wait_for_drain();
  endtask

  // Pause the source until each batch has fully drained
  task automatic test_drain_pause();
    repeat (4) begin
      repeat (6) send_random_window($urandom_range(1, 6), -1);
      wait_for_drain();
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  // Drive the result side ready with random stalls and one long hold-off
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (n - 1) @(posedge clk_i);
        end
      end
    end
  end

  // Compare each result beat with the oldest pending window
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_mags.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual magnitude %0d",
                 $time, m_axis_tdata[MAG_W-1:0]);
        mismatch_count++;
      end else begin
        if (m_axis_tdata[MAG_W-1:0] !== expected_mags[0]) begin
          $display("%0t: magnitude mismatch, expected %0d, actual %0d",
                   $time, expected_mags[0], m_axis_tdata[MAG_W-1:0]);
          mismatch_count++;
        end
        void'(expected_mags.pop_front());
        windows_checked++;
      end
    end
  end

  // Reset, run each test in turn, then report
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    grad_x        = '0;
    grad_y        = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_output_backpressure();
    test_drain_pause();
    test_random_windows(RANDOM_PIXELS);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_mags.size() != 0) begin
      $display("%0t: %0d windows never produced a result, expected none left, actual %0d",
               $time, expected_mags.size(), expected_mags.size());
      mismatch_count++;
    end
    $display("Ran %0d pixel beats forming %0d checked windows,", pixels_sent, windows_checked);
    $display("with dead taps, clamped sums, output hold-off and drain pauses.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== gradient_magnitude_3x3.f =====
+incdir+rtl
rtl/gm3_pkg.sv
rtl/gm3_datapath.sv
rtl/gm3_ctrl.sv
rtl/gradient_magnitude_3x3.sv
tb/sv/tb_gradient_magnitude_3x3.sv
